@@ hw/rtl/compound_assign_rewriter_core_defines.svh @@
// Assertion shorthands shared by the rewriter modules.
// Both expect a clock named clk and a synchronous reset named rst in scope.
`ifndef COMPOUND_ASSIGN_REWRITER_CORE_DEFINES_SVH
`define COMPOUND_ASSIGN_REWRITER_CORE_DEFINES_SVH

// same-cycle implication
`define CAR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CAR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/car_pkg.sv @@
package car_pkg;

  localparam int IDENT_MAX_DEF  = 32;
  localparam int PENDING_WS_DEF = 16;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  // what a judged byte turns into
  typedef enum logic [2:0] {
    ACT_PUT,   // release held whitespace, then the byte
    ACT_PAIR,  // "--": byte and lookahead both go out
    ACT_HOLD,  // whitespace parked in the ring
    ACT_SPOV,  // whitespace with ring full: oldest goes out
    ACT_RW     // compound operator rewrite
  } act_t;

  // source of the byte pushed to the output
  typedef enum logic [2:0] {
    SEL_SPACE,  // oldest held whitespace
    SEL_C,      // judged byte
    SEL_N,      // lookahead byte
    SEL_BLANK,  // ' '
    SEL_EQ,     // '='
    SEL_NAME    // stored name byte
  } sel_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic judge;
    logic second;
    logic emit;
    sel_t sel;
    logic pop;
    logic spov;
    logic flush;
    logic clear;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic sp_empty;
    logic sp_one;
    logic name_last;
    logic held_valid;
    logic cur_last;
    logic emit_ok;
    logic push_ok;
    logic pend_valid;
  } sts_t;

endpackage

@@ hw/rtl/car_ctrl.sv @@
`include "compound_assign_rewriter_core_defines.svh"

module car_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  car_pkg::sts_t st,
  output car_pkg::cmd_t cmd
);

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_START  = 17'h00002,
    S_JUDGE  = 17'h00004,
    S_REL    = 17'h00008,
    S_PUTC   = 17'h00010,
    S_PUTN   = 17'h00020,
    S_SPOV   = 17'h00040,
    S_RW_SP1 = 17'h00080,
    S_RW_EQ  = 17'h00100,
    S_RW_SP2 = 17'h00200,
    S_RW_NAM = 17'h00400,
    S_RW_SP3 = 17'h00800,
    S_RW_OP  = 17'h01000,
    S_RW_SP4 = 17'h02000,
    S_POST   = 17'h04000,
    S_TAIL   = 17'h08000,
    S_FLUSH  = 17'h10000
  } state_t;

  state_t        state, state_next;
  car_pkg::act_t act_q;
  logic          second;
  logic          set_second;

  assign in_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.second = second;
    set_second = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.accept = in_tvalid;
        if (in_tvalid) state_next = S_START;
      end
      S_START: begin
        if (st.held_valid) begin
          state_next = S_JUDGE;
        end else begin
          cmd.load = 1'b1;
          if (st.cur_last) begin
            set_second = 1'b1;
            state_next = S_JUDGE;
          end else begin
            state_next = S_FLUSH;
          end
        end
      end
      S_JUDGE: begin
        cmd.judge = 1'b1;
        case (st.act)
          car_pkg::ACT_PUT, car_pkg::ACT_PAIR:
            state_next = st.sp_empty ? S_PUTC : S_REL;
          car_pkg::ACT_SPOV: state_next = S_SPOV;
          car_pkg::ACT_RW:   state_next = S_RW_SP1;
          default:           state_next = S_POST;
        endcase
      end
      S_REL: begin
        cmd.sel  = car_pkg::SEL_SPACE;
        cmd.emit = st.emit_ok;
        cmd.pop  = st.emit_ok;
        if (st.emit_ok && st.sp_one) state_next = S_PUTC;
      end
      S_PUTC: begin
        cmd.sel  = car_pkg::SEL_C;
        cmd.emit = st.emit_ok;
        if (st.emit_ok) state_next = (act_q == car_pkg::ACT_PAIR) ? S_PUTN : S_POST;
      end
      S_PUTN: begin
        cmd.sel  = car_pkg::SEL_N;
        cmd.emit = st.emit_ok;
        if (st.emit_ok) state_next = S_POST;
      end
      S_SPOV: begin
        cmd.sel  = car_pkg::SEL_SPACE;
        cmd.emit = st.emit_ok;
        cmd.spov = st.emit_ok;
        if (st.emit_ok) state_next = S_POST;
      end
      S_RW_SP1: begin
        cmd.sel  = car_pkg::SEL_BLANK;
        cmd.emit = st.emit_ok;
        if (st.emit_ok) state_next = S_RW_EQ;
      end
      S_RW_EQ: begin
        cmd.sel  = car_pkg::SEL_EQ;
        cmd.emit = st.emit_ok;
        if (st.emit_ok) state_next = S_RW_SP2;
      end
      S_RW_SP2: begin
        cmd.sel  = car_pkg::SEL_BLANK;
        cmd.emit = st.emit_ok;
        if (st.emit_ok) state_next = S_RW_NAM;
      end
      S_RW_NAM: begin
        cmd.sel  = car_pkg::SEL_NAME;
        cmd.emit = st.emit_ok;
        if (st.emit_ok && st.name_last) state_next = S_RW_SP3;
      end
      S_RW_SP3: begin
        cmd.sel  = car_pkg::SEL_BLANK;
        cmd.emit = st.emit_ok;
        if (st.emit_ok) state_next = S_RW_OP;
      end
      S_RW_OP: begin
        cmd.sel  = car_pkg::SEL_C;
        cmd.emit = st.emit_ok;
        if (st.emit_ok) state_next = S_RW_SP4;
      end
      S_RW_SP4: begin
        cmd.sel  = car_pkg::SEL_BLANK;
        cmd.emit = st.emit_ok;
        if (st.emit_ok) state_next = S_POST;
      end
      S_POST: begin
        // end of text: the byte still held is judged against a zero lookahead
        if (st.cur_last && !second && st.held_valid) begin
          set_second = 1'b1;
          state_next = S_JUDGE;
        end else if (st.cur_last) begin
          state_next = S_TAIL;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_TAIL: begin
        if (st.sp_empty) begin
          state_next = S_FLUSH;
        end else begin
          cmd.sel  = car_pkg::SEL_SPACE;
          cmd.emit = st.emit_ok;
          cmd.pop  = st.emit_ok;
        end
      end
      S_FLUSH: begin
        if (!st.pend_valid || st.push_ok) begin
          cmd.flush  = st.pend_valid;
          cmd.clear  = st.cur_last;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      second <= 1'b0;
      act_q  <= car_pkg::ACT_PUT;
    end else begin
      state <= state_next;
      if (cmd.accept) second <= 1'b0;
      else if (set_second) second <= 1'b1;
      if (cmd.judge) act_q <= st.act;
    end
  end

  `CAR_ASSERT_IMP(a_emit_room, cmd.emit, st.emit_ok, "emit without output room")
  `CAR_ASSERT_IMP(a_flush_room, cmd.flush, st.pend_valid && st.push_ok, "bad flush")
  `CAR_ASSERT_IMP(a_judge_held, cmd.judge, st.held_valid, "judge with no held byte")

endmodule

@@ hw/rtl/car_dp.sv @@
`include "compound_assign_rewriter_core_defines.svh"

module car_dp #(
  parameter int IDENT_MAX  = car_pkg::IDENT_MAX_DEF,
  parameter int PENDING_WS = car_pkg::PENDING_WS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  car_pkg::cmd_t cmd,
  output car_pkg::sts_t st,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_byte,
  output logic          out_run_end,
  output logic          out_text_end
);

  localparam int LW  = $clog2(IDENT_MAX + 1);
  localparam int IW  = (IDENT_MAX > 1) ? $clog2(IDENT_MAX) : 1;
  localparam int SCW = $clog2(PENDING_WS + 1);
  localparam int SIW = (PENDING_WS > 1) ? $clog2(PENDING_WS) : 1;
  localparam int SW1 = SIW + 1;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_COMMENT,
    MODE_SQUOTE,
    MODE_DQUOTE
  } mode_t;

  function automatic logic is_name_byte(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A) || (b == car_pkg::CH_USCORE);
  endfunction

  // lexer state
  mode_t           mode;
  logic [7:0]      prior_byte;
  logic [7:0]      held_byte;
  logic            held_valid;
  logic [LW-1:0]   name_length;
  // current input word
  logic [7:0]      cur_b;
  logic            cur_last;
  // judged pair and rewrite bookkeeping
  logic [7:0]      jc, jn;
  logic [LW-1:0]   rw_len;
  logic [LW-1:0]   ridx;
  logic [7:0]      name_mem [IDENT_MAX];
  logic [7:0]      rdata;
  // held whitespace ring, 1 = tab
  logic [PENDING_WS-1:0] kinds;
  logic [SIW-1:0]  head;
  logic [SCW-1:0]  space_count;
  // last result of the run is kept back until the run ends
  logic            pend_valid;
  logic [7:0]      pend_byte;

  logic [7:0]      c, n;
  logic [7:0]      quote;
  logic            is_op;
  car_pkg::act_t   act;
  mode_t           mode_next;
  logic [LW-1:0]   nl_next;
  logic            pair;
  logic            name_wr;
  logic [SW1-1:0]  tail_sum, tail;
  logic [SIW-1:0]  tail_idx;
  logic [SIW-1:0]  head_inc;
  logic [LW-1:0]   ridx_inc, raddr_full;
  logic            emit_name;
  logic [7:0]      emit_byte;
  logic            push_ok;

  assign c     = held_byte;
  assign n     = cmd.second ? car_pkg::CH_NUL : cur_b;
  assign quote = (mode == MODE_SQUOTE) ? car_pkg::CH_SQUOTE : car_pkg::CH_DQUOTE;
  assign is_op = (c == car_pkg::CH_PLUS || c == car_pkg::CH_MINUS) && n == car_pkg::CH_EQ;

  always_comb begin
    act       = car_pkg::ACT_PUT;
    mode_next = mode;
    nl_next   = name_length;
    pair      = 1'b0;
    name_wr   = 1'b0;
    case (mode)
      MODE_COMMENT: begin
        if (c == car_pkg::CH_NL) mode_next = MODE_NORMAL;
        nl_next = '0;
      end
      MODE_SQUOTE, MODE_DQUOTE: begin
        if (c == quote && prior_byte != car_pkg::CH_BSLASH) mode_next = MODE_NORMAL;
        nl_next = '0;
      end
      default: begin
        if (c == car_pkg::CH_MINUS && n == car_pkg::CH_MINUS) begin
          act       = car_pkg::ACT_PAIR;
          mode_next = MODE_COMMENT;
          nl_next   = '0;
          pair      = 1'b1;
        end else if (c == car_pkg::CH_SQUOTE || c == car_pkg::CH_DQUOTE) begin
          mode_next = (c == car_pkg::CH_SQUOTE) ? MODE_SQUOTE : MODE_DQUOTE;
          nl_next   = '0;
        end else if (is_name_byte(c)) begin
          if (name_length < LW'(IDENT_MAX)) begin
            name_wr = 1'b1;
            nl_next = LW'(name_length + 1'b1);
          end
        end else if (c == car_pkg::CH_SPACE || c == car_pkg::CH_TAB) begin
          act = (space_count >= SCW'(PENDING_WS)) ? car_pkg::ACT_SPOV : car_pkg::ACT_HOLD;
        end else if (is_op && name_length != '0) begin
          act     = car_pkg::ACT_RW;
          nl_next = '0;
          pair    = 1'b1;
        end else if (!is_op) begin
          nl_next = '0;
        end
      end
    endcase
  end

  // ring slot after the newest held byte
  assign tail_sum = {1'b0, head} + SW1'(space_count);
  assign tail     = (tail_sum >= SW1'(PENDING_WS)) ? SW1'(tail_sum - SW1'(PENDING_WS)) : tail_sum;
  assign tail_idx = tail[SIW-1:0];
  assign head_inc = (head == SIW'(PENDING_WS - 1)) ? '0 : SIW'(head + 1'b1);

  // read address runs one ahead while name bytes go out
  assign emit_name  = cmd.emit && cmd.sel == car_pkg::SEL_NAME;
  assign ridx_inc   = LW'(ridx + 1'b1);
  assign raddr_full = emit_name ? ((ridx_inc == LW'(IDENT_MAX)) ? '0 : ridx_inc) : ridx;

  always_comb begin
    case (cmd.sel)
      car_pkg::SEL_SPACE: emit_byte = kinds[head] ? car_pkg::CH_TAB : car_pkg::CH_SPACE;
      car_pkg::SEL_C:     emit_byte = jc;
      car_pkg::SEL_N:     emit_byte = jn;
      car_pkg::SEL_BLANK: emit_byte = car_pkg::CH_SPACE;
      car_pkg::SEL_EQ:    emit_byte = car_pkg::CH_EQ;
      car_pkg::SEL_NAME:  emit_byte = rdata;
      default:            emit_byte = car_pkg::CH_SPACE;
    endcase
  end

  assign push_ok = !out_tvalid || out_tready;

  always_comb begin
    st            = '0;
    st.act        = act;
    st.sp_empty   = (space_count == '0);
    st.sp_one     = (space_count == SCW'(1));
    st.name_last  = (ridx == LW'(rw_len - 1'b1));
    st.held_valid = held_valid;
    st.cur_last   = cur_last;
    st.push_ok    = push_ok;
    st.emit_ok    = !pend_valid || push_ok;
    st.pend_valid = pend_valid;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      mode        <= MODE_NORMAL;
      prior_byte  <= '0;
      held_byte   <= '0;
      held_valid  <= 1'b0;
      name_length <= '0;
    end else begin
      if (cmd.load) begin
        held_byte  <= cur_b;
        held_valid <= 1'b1;
      end
      if (cmd.judge) begin
        mode        <= mode_next;
        name_length <= nl_next;
        prior_byte  <= pair ? n : c;
        if (!cmd.second) begin
          if (pair) held_valid <= 1'b0;
          else      held_byte  <= cur_b;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      head        <= '0;
      space_count <= '0;
    end else begin
      if (cmd.judge && act == car_pkg::ACT_HOLD) space_count <= SCW'(space_count + 1'b1);
      else if (cmd.judge && act == car_pkg::ACT_RW) space_count <= '0;
      else if (cmd.pop) space_count <= SCW'(space_count - 1'b1);
      if (cmd.pop || cmd.spov) head <= head_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.judge && act == car_pkg::ACT_HOLD) kinds[tail_idx] <= (c == car_pkg::CH_TAB);
    // full ring: the oldest slot is reused for the newest
    if (cmd.spov) kinds[head] <= (jc == car_pkg::CH_TAB);
  end

  always_ff @(posedge clk) begin
    if (cmd.judge && name_wr) name_mem[name_length[IW-1:0]] <= c;
    rdata <= name_mem[raddr_full[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_b    <= in_byte;
      cur_last <= in_last;
    end
    if (cmd.judge) begin
      jc     <= c;
      jn     <= n;
      rw_len <= name_length;
      ridx   <= '0;
    end else if (emit_name) begin
      ridx <= ridx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.flush || (cmd.emit && pend_valid)) out_tvalid <= 1'b1;
      else if (out_tready) out_tvalid <= 1'b0;
      if (cmd.emit) pend_valid <= 1'b1;
      else if (cmd.flush) pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pend_byte <= emit_byte;
      if (pend_valid) begin
        out_byte     <= pend_byte;
        out_run_end  <= 1'b0;
        out_text_end <= 1'b0;
      end
    end else if (cmd.flush) begin
      out_byte     <= pend_byte;
      out_run_end  <= 1'b1;
      out_text_end <= cur_last;
    end
  end

  `CAR_ASSERT_IMP(a_ring_bound, 1'b1, space_count <= SCW'(PENDING_WS), "ring overfilled")
  `CAR_ASSERT_NXT(a_clear_state, cmd.clear, !held_valid && name_length == '0 && space_count == '0,
                  "state not cleared at end of text")
  `CAR_ASSERT_IMP(a_text_end_run, out_tvalid && out_text_end, out_run_end, "text end off a run end")

endmodule

@@ hw/rtl/compound_assign_rewriter_core.sv @@
// channel  | dir | tdata             | tuser      | tlast
// s_axis   | in  | [7:0] in_byte     | -          | in_last
// m_axis   | out | [7:0] out_byte    | [0] run_end| out_text_end
//
// A word steps through accept, start, judge, its output bytes (released spaces
// included), post and flush, from the accept to the next ready.
// The first word of a text only loads. The end-of-text word adds a tail
// step, plus a judge and a post step when a byte is still held.
// A rewrite emits its name one byte a cycle from the name RAM read port while
// the output has room. rst clears lexer state and handshakes, not the name RAM.
// Without output room the word stalls; the input waits until the run is flushed.
module compound_assign_rewriter_core #(
  parameter int IDENT_MAX  = car_pkg::IDENT_MAX_DEF,
  parameter int PENDING_WS = car_pkg::PENDING_WS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [0:0] m_axis_tuser,   // [0] out_run_end
  output logic       m_axis_tlast
);

  car_pkg::cmd_t cmd;
  car_pkg::sts_t st;
  logic          run_end;

  car_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (s_axis_tvalid),
    .in_tready (s_axis_tready),
    .st        (st),
    .cmd       (cmd)
  );

  car_dp #(
    .IDENT_MAX  (IDENT_MAX),
    .PENDING_WS (PENDING_WS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .in_byte      (s_axis_tdata),
    .in_last      (s_axis_tlast),
    .out_tvalid   (m_axis_tvalid),
    .out_tready   (m_axis_tready),
    .out_byte     (m_axis_tdata),
    .out_run_end  (run_end),
    .out_text_end (m_axis_tlast)
  );

  assign m_axis_tuser = run_end;

endmodule

@@ verif/tb_compound_assign_rewriter_core.sv @@
module tb_compound_assign_rewriter_core;

  localparam int NAME_CAP    = car_pkg::IDENT_MAX_DEF;
  localparam int SPACE_CAP   = car_pkg::PENDING_WS_DEF;
  localparam int ITEM_TARGET = 410;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 60;

  typedef enum logic [1:0] {
    LEX_NORMAL,
    LEX_COMMENT,
    LEX_SQUOTE,
    LEX_DQUOTE
  } lex_mode_t;

  typedef struct {
    logic [7:0] data;
    bit         run_end;
    bit         text_end;
  } out_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic [0:0] m_axis_tuser;           // [0] out_run_end
  logic       m_axis_tlast;

  bit steady = 1'b0;
  int items_sent = 0;
  int idle_cycles = 0;

  compound_assign_rewriter_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  class rewrite_ledger;
    lex_mode_t  mode;
    logic [7:0] prior;
    logic [7:0] held;
    bit         held_ok;
    logic [7:0] name_q[$];
    logic [7:0] spaces[$];
    out_word_t  step_words[$];
    out_word_t  rewritten_words[$];
    int         errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      mode    = LEX_NORMAL;
      prior   = car_pkg::CH_NUL;
      held    = car_pkg::CH_NUL;
      held_ok = 1'b0;
      name_q.delete();
      spaces.delete();
    endfunction

    function void emit_raw(logic [7:0] b);
      out_word_t w;
      w.data     = b;
      w.run_end  = 1'b0;
      w.text_end = 1'b0;
      step_words.push_back(w);
    endfunction

    function void flush_spaces();
      foreach (spaces[i]) emit_raw(spaces[i]);
      spaces.delete();
    endfunction

    function void emit(logic [7:0] b);
      flush_spaces();
      emit_raw(b);
    endfunction

    function bit is_word_char(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
             (c >= "a" && c <= "z") || c == car_pkg::CH_USCORE;
    endfunction

    // returns 1 when the lookahead byte is consumed as well
    function bit judge_byte(logic [7:0] c, logic [7:0] n);
      bit pair;
      bit op;
      logic [7:0] q;
      pair = 1'b0;
      if (mode == LEX_COMMENT) begin
        emit(c);
        if (c == car_pkg::CH_NL) mode = LEX_NORMAL;
        name_q.delete();
      end else if (mode == LEX_SQUOTE || mode == LEX_DQUOTE) begin
        q = (mode == LEX_SQUOTE) ? car_pkg::CH_SQUOTE : car_pkg::CH_DQUOTE;
        emit(c);
        if (c == q && prior != car_pkg::CH_BSLASH) mode = LEX_NORMAL;
        name_q.delete();
      end else if (c == car_pkg::CH_MINUS && n == car_pkg::CH_MINUS) begin
        emit(c);
        emit(n);
        mode = LEX_COMMENT;
        name_q.delete();
        pair = 1'b1;
      end else if (c == car_pkg::CH_SQUOTE || c == car_pkg::CH_DQUOTE) begin
        emit(c);
        mode = (c == car_pkg::CH_SQUOTE) ? LEX_SQUOTE : LEX_DQUOTE;
        name_q.delete();
      end else if (is_word_char(c)) begin
        if (name_q.size() < NAME_CAP) name_q.push_back(c);
        emit(c);
      end else if (c == car_pkg::CH_SPACE || c == car_pkg::CH_TAB) begin
        if (spaces.size() >= SPACE_CAP) emit_raw(spaces.pop_front());
        spaces.push_back(c);
      end else begin
        op = (c == car_pkg::CH_PLUS || c == car_pkg::CH_MINUS) && n == car_pkg::CH_EQ;
        if (op && name_q.size() > 0) begin
          spaces.delete();
          emit_raw(car_pkg::CH_SPACE);
          emit_raw(car_pkg::CH_EQ);
          emit_raw(car_pkg::CH_SPACE);
          foreach (name_q[i]) emit_raw(name_q[i]);
          emit_raw(car_pkg::CH_SPACE);
          emit_raw(c);
          emit_raw(car_pkg::CH_SPACE);
          name_q.delete();
          pair = 1'b1;
        end else begin
          if (!op) name_q.delete();
          emit(c);
        end
      end
      prior = pair ? n : c;
      return pair;
    endfunction

    function void take_source_byte(logic [7:0] b, bit last);
      step_words.delete();
      if (held_ok) begin
        if (judge_byte(held, b)) held_ok = 1'b0;
        else held = b;
      end else begin
        held    = b;
        held_ok = 1'b1;
      end
      if (last) begin
        if (held_ok) void'(judge_byte(held, car_pkg::CH_NUL));
        held_ok = 1'b0;
        flush_spaces();
      end
      if (step_words.size() > 0) begin
        step_words[step_words.size() - 1].run_end = 1'b1;
        if (last) step_words[step_words.size() - 1].text_end = 1'b1;
      end
      foreach (step_words[i]) rewritten_words.push_back(step_words[i]);
      if (last) clear_state();
    endfunction

    function void match_output_word(logic [7:0] b, bit run_end, bit text_end);
      out_word_t w;
      if (rewritten_words.size() == 0) begin
        $error("unexpected output word %h", b);
        errors++;
        return;
      end
      w = rewritten_words.pop_front();
      if (b !== w.data) begin
        $error("out_byte: expected %h, got %h", w.data, b);
        errors++;
      end
      if (run_end !== w.run_end) begin
        $error("out_run_end: expected %0d, got %0d", w.run_end, run_end);
        errors++;
      end
      if (text_end !== w.text_end) begin
        $error("out_text_end: expected %0d, got %0d", w.text_end, text_end);
        errors++;
      end
    endfunction

    function int outstanding();
      return rewritten_words.size();
    endfunction
  endclass

  rewrite_ledger ledger = new();

  // mostly short gaps, a few long ones, none in steady stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] name_char();
    int k;
    k = $urandom_range(0, 62);
    if (k < 26) return 8'("a" + k);
    if (k < 52) return 8'("A" + (k - 26));
    if (k < 62) return 8'("0" + (k - 52));
    return car_pkg::CH_USCORE;
  endfunction

  function automatic void push_str(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic void add_name(ref logic [7:0] q[$]);
    int len;
    len = ($urandom_range(0, 99) < 5) ? $urandom_range(30, 40) : $urandom_range(1, 5);
    repeat (len) q.push_back(name_char());
  endfunction

  function automatic void add_spaces(ref logic [7:0] q[$]);
    int len;
    len = ($urandom_range(0, 99) < 6) ? $urandom_range(15, 20) : $urandom_range(0, 2);
    repeat (len) q.push_back($urandom_range(0, 3) == 0 ? car_pkg::CH_TAB : car_pkg::CH_SPACE);
  endfunction

  function automatic void add_token(ref logic [7:0] q[$]);
    int kind;
    logic [7:0] qt;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      // name, op, value: the shape that reaches a rewrite
      add_name(q);
      add_spaces(q);
      q.push_back($urandom_range(0, 1) ? car_pkg::CH_PLUS : car_pkg::CH_MINUS);
      q.push_back(car_pkg::CH_EQ);
      add_spaces(q);
      if ($urandom_range(0, 1)) add_name(q);
      else q.push_back(8'("0" + $urandom_range(0, 9)));
    end else if (kind < 50) begin
      add_name(q);
    end else if (kind < 58) begin
      add_spaces(q);
    end else if (kind < 66) begin
      q.push_back($urandom_range(0, 1) ? car_pkg::CH_PLUS : car_pkg::CH_MINUS);
      if ($urandom_range(0, 1)) q.push_back(car_pkg::CH_EQ);
    end else if (kind < 72) begin
      case ($urandom_range(0, 5))
        0: q.push_back("(");
        1: q.push_back(")");
        2: q.push_back(car_pkg::CH_EQ);
        3: q.push_back(car_pkg::CH_NL);
        4: q.push_back(",");
        default: q.push_back(car_pkg::CH_BSLASH);
      endcase
    end else if (kind < 80) begin
      q.push_back(car_pkg::CH_MINUS);
      q.push_back(car_pkg::CH_MINUS);
      repeat ($urandom_range(0, 4)) q.push_back(name_char());
      if ($urandom_range(0, 9) < 7) q.push_back(car_pkg::CH_NL);
    end else if (kind < 92) begin
      qt = $urandom_range(0, 1) ? car_pkg::CH_SQUOTE : car_pkg::CH_DQUOTE;
      q.push_back(qt);
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            q.push_back(car_pkg::CH_BSLASH);
            q.push_back($urandom_range(0, 1) ? qt : name_char());
          end
          2: q.push_back(qt == car_pkg::CH_SQUOTE ? car_pkg::CH_DQUOTE : car_pkg::CH_SQUOTE);
          3: q.push_back(8'($urandom_range(0, 255)));
          default: q.push_back(name_char());
        endcase
      end
      if ($urandom_range(0, 9) < 8) q.push_back(qt);
    end else begin
      q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tlast  = last;
    do @(posedge clk); while (!s_axis_tready);
    ledger.take_source_byte(b, last);
    items_sent++;
  endtask

  task automatic send_text(input logic [7:0] txt[$]);
    foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
  endtask

  // receiver: random stalls
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      ledger.match_output_word(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] txt[$];
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // name split by a space, then a rewrite
    txt.delete();
    push_str(txt, "a b+=1");
    send_text(txt);
    // tab before the minus form, then a line comment
    txt.delete();
    push_str(txt, "x\t-=y--c\n");
    send_text(txt);
    // escaped quote inside a string, then a double-quoted one
    txt.delete();
    push_str(txt, "'\\''\"a\"");
    send_text(txt);
    // single-byte texts at the byte extremes
    send_byte(car_pkg::CH_NUL, 1'b1);
    send_byte(8'hFF, 1'b1);

    while (items_sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 4) == 0);
      txt.delete();
      repeat ($urandom_range(1, 6)) add_token(txt);
      if (txt.size() == 0) txt.push_back(8'($urandom_range(0, 255)));
      send_text(txt);
    end
    steady = 1'b0;

    @(negedge clk);
    s_axis_tvalid = 1'b0;
    s_axis_tlast  = 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (ledger.errors == 0 && ledger.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/car_pkg.sv
hw/rtl/car_ctrl.sv
hw/rtl/car_dp.sv
hw/rtl/compound_assign_rewriter_core.sv
verif/tb_compound_assign_rewriter_core.sv
